### src/bges_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bges_pkg
// shared types and codes for the button gesture and encoder step block
// ----------------------------------------------------------------------------
package bges_pkg;

  localparam int CFG_W   = 16;
  localparam int COUNT_W = 8;
  localparam int CIDX_W  = 2;

  // register indexes on the config port
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DOUBLE_CLICK = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LONG_PRESS   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd40;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd350;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd700;

  // encoder step codes
  localparam logic signed [1:0] STEP_NONE  = 2'sb00;
  localparam logic signed [1:0] STEP_RIGHT = 2'sb01;
  localparam logic signed [1:0] STEP_LEFT  = 2'sb11;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] double_click_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic               enc_clk_level;
    logic               enc_data_level;
    logic               button_level;
  } tick_t;

  typedef struct packed {
    logic signed [1:0]  enc_step;
    event_t             button_event;
    logic [COUNT_W-1:0] click_count;
    logic               button_pressed;
  } result_t;

endpackage

### src/button_gesture_and_encoder_step.sv
`timescale 1ns / 1ps
// an accepted request is loaded into the input register and then its result
// into the result register, from which it is offered; a stall can come between
// throughput: one request per cycle while the output is not stalled; the tick
// update is one pass of logic between the two registers and the state feeds back
// reset: timers and click count clear, lines read idle high, registers
// return to debounce 40, double click 350, long press 700
// ----------------------------------------------------------------------------
// button_gesture_and_encoder_step
// rotary encoder step decode and debounced click / double click / long press
// ----------------------------------------------------------------------------
module button_gesture_and_encoder_step #(
  parameter int TIMER_WIDTH = 16,
  parameter int CLICK_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          enc_clk_level,
  input  logic                          enc_data_level,
  input  logic                          button_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [1:0]             enc_step,
  output logic [1:0]                    button_event,
  output logic [bges_pkg::COUNT_W-1:0]  click_count,
  output logic                          button_pressed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bges_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bges_pkg::CFG_W-1:0]    cfg_data
);
  import bges_pkg::*;

  cfg_t    cfg;
  tick_t   s1_tick;
  logic    s1_valid;
  logic    advance;
  result_t result;
  result_t out_reg;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  bges_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bges_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .CLICK_WIDTH (CLICK_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (s1_tick),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tick.enc_clk_level  <= enc_clk_level;
      s1_tick.enc_data_level <= enc_data_level;
      s1_tick.button_level   <= button_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign enc_step       = out_reg.enc_step;
  assign button_event   = out_reg.button_event;
  assign click_count    = out_reg.click_count;
  assign button_pressed = out_reg.button_pressed;

`ifndef SYNTH
  a_click_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && button_event == EV_CLICK |-> click_count == COUNT_W'(1))
    else $error("single click without count of one");

  a_click_double : assert property (@(posedge clk) disable iff (rst)
    out_valid && button_event == EV_DOUBLE |-> click_count >= COUNT_W'(2))
    else $error("double click with count below two");

  a_no_count : assert property (@(posedge clk) disable iff (rst)
    out_valid && (button_event == EV_NONE || button_event == EV_LONG)
      |-> click_count == '0)
    else $error("click count set without a click event");

  a_long_held : assert property (@(posedge clk) disable iff (rst)
    out_valid && button_event == EV_LONG |-> button_pressed)
    else $error("long press reported while released");

  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_tick))
    else $error("stalled tick lost from input register");
`endif

endmodule

### src/bges_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bges_cfg
// configuration register file for debounce, double click and long press times
// ----------------------------------------------------------------------------
module bges_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [bges_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bges_pkg::CFG_W-1:0]   cfg_data,
  output bges_pkg::cfg_t               cfg
);
  import bges_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RST;
      cfg.double_click_ticks <= DOUBLE_CLICK_RST;
      cfg.long_press_ticks   <= LONG_PRESS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ticks <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/bges_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bges_core
// per-tick state update: encoder edge, debounce, long press and click timing
// ----------------------------------------------------------------------------
module bges_core #(
  parameter int TIMER_WIDTH = 16,
  parameter int CLICK_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  bges_pkg::tick_t   tick,
  input  bges_pkg::cfg_t    cfg,
  output bges_pkg::result_t result
);
  import bges_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam int CNT_W = (CLICK_WIDTH > COUNT_W) ? CLICK_WIDTH : COUNT_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [CLICK_WIDTH-1:0] CLICK_MAX = {CLICK_WIDTH{1'b1}};
  localparam logic [CNT_W-1:0]       COUNT_MAX = CNT_W'({COUNT_W{1'b1}});

  logic                   prev_clk, prev_clk_next;
  logic                   prev_raw, prev_raw_next;
  logic                   stable, stable_next;
  logic [TIMER_WIDTH-1:0] since_raw, since_raw_next;
  logic [TIMER_WIDTH-1:0] since_press, since_press_next;
  logic [TIMER_WIDTH-1:0] since_release, since_release_next;
  logic                   long_reported, long_reported_next;
  logic [CLICK_WIDTH-1:0] pending, pending_next;
  logic [CNT_W-1:0]       pending_ext;

  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    return (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
  endfunction

  always_comb begin
    result.enc_step       = STEP_NONE;
    result.button_event   = EV_NONE;
    result.click_count    = '0;

    if (prev_clk && !tick.enc_clk_level) begin
      result.enc_step = tick.enc_data_level ? STEP_LEFT : STEP_RIGHT;
    end
    prev_clk_next = tick.enc_clk_level;

    since_press_next   = sat_inc(since_press);
    since_release_next = sat_inc(since_release);
    since_raw_next     = (tick.button_level != prev_raw) ? '0 : sat_inc(since_raw);
    prev_raw_next      = tick.button_level;
    stable_next        = stable;
    long_reported_next = long_reported;
    pending_next       = pending;

    // debounced edge
    if (CMP_W'(since_raw_next) >= CMP_W'(cfg.debounce_ticks) &&
        tick.button_level != stable) begin
      stable_next = tick.button_level;
      if (!tick.button_level) begin
        since_press_next   = '0;
        long_reported_next = 1'b0;
      end else if (!long_reported) begin
        if (pending != CLICK_MAX) pending_next = pending + 1'b1;
        since_release_next = '0;
      end
    end

    // long press while held
    if (!stable_next && !long_reported_next &&
        CMP_W'(since_press_next) >= CMP_W'(cfg.long_press_ticks)) begin
      long_reported_next  = 1'b1;
      pending_next        = '0;
      result.button_event = EV_LONG;
    end

    // resolve clicks once the double click window has passed
    pending_ext = CNT_W'(pending_next);
    if (pending_next != '0 &&
        CMP_W'(since_release_next) >= CMP_W'(cfg.double_click_ticks)) begin
      result.button_event = (pending_next == CLICK_WIDTH'(1)) ? EV_CLICK : EV_DOUBLE;
      result.click_count  = (pending_ext > COUNT_MAX) ? {COUNT_W{1'b1}}
                                                      : pending_ext[COUNT_W-1:0];
      pending_next        = '0;
    end

    result.button_pressed = !stable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_clk      <= 1'b1;
      prev_raw      <= 1'b1;
      stable        <= 1'b1;
      since_raw     <= '0;
      since_press   <= '0;
      since_release <= '0;
      long_reported <= 1'b0;
      pending       <= '0;
    end else if (advance) begin
      prev_clk      <= prev_clk_next;
      prev_raw      <= prev_raw_next;
      stable        <= stable_next;
      since_raw     <= since_raw_next;
      since_press   <= since_press_next;
      since_release <= since_release_next;
      long_reported <= long_reported_next;
      pending       <= pending_next;
    end
  end

endmodule
